FILE: rtl/fpp_pkg.sv
package fpp_pkg;

   localparam int COORD_WIDTH  = 32;
   localparam int CW           = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
   localparam int FRONT_STAGES = 2;
   localparam int FCNT_W       = $clog2(FRONT_STAGES + 1);
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int SQRT_STEPS   = 32;
   localparam int DIV_STEPS    = 31;

   typedef logic signed [31:0] coord_type;

   typedef struct packed {
      logic [2:0]       tag;
      logic [2:0][31:0] p0;
      logic [2:0][66:0] c;
   } entry_type;

   typedef struct packed {
      logic [2:0]       tag;
      logic             deg;
      logic [2:0]       neg;
      logic [2:0][31:0] p0;
      logic [2:0][30:0] v;
   } side_type;

   function automatic coord_type coord_ext(input logic [31:0] raw);
      coord_type s;
      s = coord_type'(raw << (32 - CW));
      return s >>> (32 - CW);
   endfunction

endpackage

FILE: rtl/fpp_front.sv
module fpp_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_accept,
   input  logic [2:0]                   in_tag,
   input  logic [2:0][31:0]             in_first,
   input  logic [2:0][31:0]             in_second,
   input  logic [2:0][31:0]             in_third,
   output logic                         wr_valid,
   output fpp_pkg::entry_type           wr_entry,
   output logic [fpp_pkg::FCNT_W-1:0]   busy
);

   logic                f1_valid_ff;
   logic [2:0]          f1_tag_ff;
   logic [2:0][31:0]    f1_p0_ff;
   logic signed [32:0]  f1_d1_ff [3];
   logic signed [32:0]  f1_d2_ff [3];
   logic [2:0][31:0]    p0_in;
   logic signed [32:0]  d1_in [3];
   logic signed [32:0]  d2_in [3];

   logic                f2_valid_ff;
   logic [2:0]          f2_tag_ff;
   logic [2:0][31:0]    f2_p0_ff;
   logic signed [65:0]  f2_prod_ff [6];
   logic signed [65:0]  prod_in [6];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p0_in[i] = fpp_pkg::coord_ext(in_first[i]);
         d1_in[i] = 33'(fpp_pkg::coord_ext(in_second[i]))
                    - 33'(fpp_pkg::coord_ext(in_first[i]));
         d2_in[i] = 33'(fpp_pkg::coord_ext(in_third[i]))
                    - 33'(fpp_pkg::coord_ext(in_first[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= in_accept;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         f1_tag_ff <= in_tag;
         f1_p0_ff  <= p0_in;
         for (int i = 0; i < 3; i++) begin
            f1_d1_ff[i] <= d1_in[i];
            f1_d2_ff[i] <= d2_in[i];
         end
      end
   end

   always_comb begin
      prod_in[0] = f1_d1_ff[1] * f1_d2_ff[2];
      prod_in[1] = f1_d1_ff[2] * f1_d2_ff[1];
      prod_in[2] = f1_d1_ff[2] * f1_d2_ff[0];
      prod_in[3] = f1_d1_ff[0] * f1_d2_ff[2];
      prod_in[4] = f1_d1_ff[0] * f1_d2_ff[1];
      prod_in[5] = f1_d1_ff[1] * f1_d2_ff[0];
   end

   always_ff @(posedge clock) begin
      if (f1_valid_ff) begin
         f2_tag_ff <= f1_tag_ff;
         f2_p0_ff  <= f1_p0_ff;
         for (int i = 0; i < 6; i++) begin
            f2_prod_ff[i] <= prod_in[i];
         end
      end
   end

   always_comb begin
      wr_valid        = f2_valid_ff;
      wr_entry.tag    = f2_tag_ff;
      wr_entry.p0     = f2_p0_ff;
      wr_entry.c[0]   = 67'(f2_prod_ff[0]) - 67'(f2_prod_ff[1]);
      wr_entry.c[1]   = 67'(f2_prod_ff[2]) - 67'(f2_prod_ff[3]);
      wr_entry.c[2]   = 67'(f2_prod_ff[4]) - 67'(f2_prod_ff[5]);
      busy = fpp_pkg::FCNT_W'(f1_valid_ff) + fpp_pkg::FCNT_W'(f2_valid_ff);
   end

endmodule

FILE: rtl/fpp_queue.sv
module fpp_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  fpp_pkg::entry_type           push_entry,
   input  logic                         pop,
   output fpp_pkg::entry_type           pop_entry,
   output logic [fpp_pkg::QCNT_W-1:0]   count
);

   fpp_pkg::entry_type               q_mem_ff [fpp_pkg::QUEUE_DEPTH];
   logic [fpp_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [fpp_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [fpp_pkg::QCNT_W-1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == fpp_pkg::QPTR_W'(fpp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == fpp_pkg::QPTR_W'(fpp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + fpp_pkg::QCNT_W'(push) - fpp_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_entry = q_mem_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

FILE: rtl/fpp_back.sv
module fpp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 avail,
   input  fpp_pkg::entry_type   entry,
   output logic                 pop,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic [2:0]           rsp_tag_out,
   output logic signed [31:0]   rsp_normal_x,
   output logic signed [31:0]   rsp_normal_y,
   output logic signed [31:0]   rsp_normal_z,
   output logic signed [31:0]   rsp_plane_offset,
   output logic                 rsp_degenerate
);

   localparam int SQ = fpp_pkg::SQRT_STEPS;
   localparam int DV = fpp_pkg::DIV_STEPS;

   logic en;

   logic                b1_valid_ff;
   logic [2:0]          b1_tag_ff;
   logic [2:0]          b1_neg_ff, neg_in;
   logic [2:0][31:0]    b1_p0_ff;
   logic [2:0][65:0]    b1_m_ff, m_in;

   logic                b2_valid_ff;
   logic [2:0]          b2_tag_ff;
   logic [2:0]          b2_neg_ff;
   logic [2:0][31:0]    b2_p0_ff;
   logic [2:0][65:0]    b2_m_ff;
   logic [6:0]          b2_top_ff, top_in;
   logic [65:0]         m_or;

   logic                b3_valid_ff;
   fpp_pkg::side_type   b3_side_ff, b3_side_in;
   logic [65:0]         shifted [3];

   logic                b4_valid_ff;
   fpp_pkg::side_type   b4_side_ff;
   logic [2:0][61:0]    b4_sq_ff, sq_in;
   logic [63:0]         sum_in;

   logic                sr_valid_ff [0:SQ];
   fpp_pkg::side_type   sr_side_ff  [0:SQ];
   logic [63:0]         sr_rem_ff   [0:SQ];
   logic [31:0]         sr_root_ff  [0:SQ];

   logic                dv_valid_ff [0:DV];
   fpp_pkg::side_type   dv_side_ff  [0:DV];
   logic [31:0]         dv_len_ff   [0:DV];
   logic [2:0][31:0]    dv_rem_ff   [0:DV];
   logic [2:0][30:0]    dv_low_ff   [0:DV];
   logic [2:0][30:0]    dv_q_ff     [0:DV];
   logic [2:0][61:0]    num_in;

   logic                e1_valid_ff;
   fpp_pkg::side_type   e1_side_ff;
   logic [2:0][31:0]    e1_n_ff, n_in;

   logic                e2_valid_ff;
   logic [2:0]          e2_tag_ff;
   logic                e2_deg_ff;
   logic [2:0][31:0]    e2_n_ff;
   logic signed [63:0]  e2_prod_ff [3];

   logic                e3_valid_ff;
   logic [2:0]          e3_tag_ff;
   logic                e3_deg_ff;
   logic [2:0][31:0]    e3_n_ff;
   logic signed [63:0]  e3_dot_ff;

   logic signed [64:0]  t_neg;
   logic [63:0]         t_mag;
   logic [64:0]         t_rnd;
   logic [34:0]         t_q, t_negq;
   logic [31:0]         off_in;

   logic                out_valid_ff;
   logic [2:0]          out_tag_ff;
   logic [2:0][31:0]    out_n_ff;
   logic [31:0]         out_off_ff;
   logic                out_deg_ff;

   assign en  = !out_valid_ff || !rsp_stall;
   assign pop = en && avail;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = entry.c[i][66];
         m_in[i]   = entry.c[i][66] ? 66'(-$signed(entry.c[i])) : entry.c[i][65:0];
      end
   end

   always_comb begin
      m_or   = b1_m_ff[0] | b1_m_ff[1] | b1_m_ff[2];
      top_in = '0;
      for (int k = 0; k < 66; k++) begin
         if (m_or[k]) top_in = 7'(k + 1);
      end
   end

   always_comb begin
      b3_side_in.tag = b2_tag_ff;
      b3_side_in.deg = (b2_top_ff == 7'd0);
      b3_side_in.neg = b2_neg_ff;
      b3_side_in.p0  = b2_p0_ff;
      for (int i = 0; i < 3; i++) begin
         if (b2_top_ff > 7'd31) shifted[i] = b2_m_ff[i] >> (b2_top_ff - 7'd31);
         else                   shifted[i] = b2_m_ff[i] << (7'd31 - b2_top_ff);
         b3_side_in.v[i] = shifted[i][30:0];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = {31'd0, b3_side_ff.v[i]} * {31'd0, b3_side_ff.v[i]};
      end
      sum_in = 64'(b4_sq_ff[0]) + 64'(b4_sq_ff[1]) + 64'(b4_sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff    <= 1'b0;
         b2_valid_ff    <= 1'b0;
         b3_valid_ff    <= 1'b0;
         b4_valid_ff    <= 1'b0;
         sr_valid_ff[0] <= 1'b0;
      end else if (en) begin
         b1_valid_ff    <= pop;
         b2_valid_ff    <= b1_valid_ff;
         b3_valid_ff    <= b2_valid_ff;
         b4_valid_ff    <= b3_valid_ff;
         sr_valid_ff[0] <= b4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b1_tag_ff     <= entry.tag;
         b1_neg_ff     <= neg_in;
         b1_p0_ff      <= entry.p0;
         b1_m_ff       <= m_in;
         b2_tag_ff     <= b1_tag_ff;
         b2_neg_ff     <= b1_neg_ff;
         b2_p0_ff      <= b1_p0_ff;
         b2_m_ff       <= b1_m_ff;
         b2_top_ff     <= top_in;
         b3_side_ff    <= b3_side_in;
         b4_side_ff    <= b3_side_ff;
         b4_sq_ff      <= sq_in;
         sr_side_ff[0] <= b4_side_ff;
         sr_rem_ff[0]  <= sum_in;
         sr_root_ff[0] <= '0;
      end
   end

   for (genvar j = 1; j <= SQ; j++) begin : g_sqrt
      localparam int BIT = SQ - j;
      logic [65:0] trial;
      logic        take;
      logic [63:0] rem_in;
      logic [31:0] root_in;

      always_comb begin
         trial   = ({34'd0, sr_root_ff[j-1]} << (BIT + 1)) + (66'd1 << (2 * BIT));
         take    = {2'b00, sr_rem_ff[j-1]} >= trial;
         rem_in  = take ? sr_rem_ff[j-1] - trial[63:0] : sr_rem_ff[j-1];
         root_in = take ? sr_root_ff[j-1] | (32'd1 << BIT) : sr_root_ff[j-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sr_valid_ff[j] <= 1'b0;
         end else if (en) begin
            sr_valid_ff[j] <= sr_valid_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sr_side_ff[j] <= sr_side_ff[j-1];
            sr_rem_ff[j]  <= rem_in;
            sr_root_ff[j] <= root_in;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num_in[i] = {sr_side_ff[SQ].v[i], 30'd0} + 62'(sr_root_ff[SQ][31:1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (en) begin
         dv_valid_ff[0] <= sr_valid_ff[SQ];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_side_ff[0] <= sr_side_ff[SQ];
         dv_len_ff[0]  <= sr_root_ff[SQ];
         dv_q_ff[0]    <= '0;
         for (int i = 0; i < 3; i++) begin
            dv_rem_ff[0][i] <= 32'(num_in[i][61:31]);
            dv_low_ff[0][i] <= num_in[i][30:0];
         end
      end
   end

   for (genvar j = 1; j <= DV; j++) begin : g_div
      localparam int BIT = DV - j;
      logic [32:0]      part [3];
      logic [2:0]       ge;
      logic [2:0][31:0] rem_in;
      logic [2:0][30:0] q_in;

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            part[i]   = {dv_rem_ff[j-1][i], dv_low_ff[j-1][i][BIT]};
            ge[i]     = part[i] >= {1'b0, dv_len_ff[j-1]};
            rem_in[i] = ge[i] ? 32'(part[i] - {1'b0, dv_len_ff[j-1]}) : part[i][31:0];
            q_in[i]   = dv_q_ff[j-1][i] | (31'(ge[i]) << BIT);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j] <= 1'b0;
         end else if (en) begin
            dv_valid_ff[j] <= dv_valid_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_side_ff[j] <= dv_side_ff[j-1];
            dv_len_ff[j]  <= dv_len_ff[j-1];
            dv_low_ff[j]  <= dv_low_ff[j-1];
            dv_rem_ff[j]  <= rem_in;
            dv_q_ff[j]    <= q_in;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_in[i] = dv_side_ff[DV].neg[i] ? 32'(-$signed({1'b0, dv_q_ff[DV][i]}))
                                        : {1'b0, dv_q_ff[DV][i]};
      end
   end

   always_comb begin
      t_neg = -(65'(e3_dot_ff));
      t_mag = t_neg[64] ? 64'(-t_neg) : t_neg[63:0];
      t_rnd = 65'(t_mag) + (65'd1 << 29);
      t_q   = t_rnd[64:30];
      t_negq = -t_q;
      if (t_neg[64]) begin
         off_in = (t_q > 35'h080000000) ? 32'h80000000 : t_negq[31:0];
      end else begin
         off_in = (t_q > 35'h07FFFFFFF) ? 32'h7FFFFFFF : t_q[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff  <= 1'b0;
         e2_valid_ff  <= 1'b0;
         e3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         e1_valid_ff  <= dv_valid_ff[DV];
         e2_valid_ff  <= e1_valid_ff;
         e3_valid_ff  <= e2_valid_ff;
         out_valid_ff <= e3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_side_ff <= dv_side_ff[DV];
         e1_n_ff    <= n_in;
         e2_tag_ff  <= e1_side_ff.tag;
         e2_deg_ff  <= e1_side_ff.deg;
         e2_n_ff    <= e1_n_ff;
         for (int i = 0; i < 3; i++) begin
            e2_prod_ff[i] <= $signed(e1_n_ff[i]) * $signed(e1_side_ff.p0[i]);
         end
         e3_tag_ff  <= e2_tag_ff;
         e3_deg_ff  <= e2_deg_ff;
         e3_n_ff    <= e2_n_ff;
         e3_dot_ff  <= e2_prod_ff[0] + e2_prod_ff[1] + e2_prod_ff[2];
         out_tag_ff <= e3_tag_ff;
         out_deg_ff <= e3_deg_ff;
         out_n_ff   <= e3_deg_ff ? '0 : e3_n_ff;
         out_off_ff <= e3_deg_ff ? '0 : off_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_tag_out      = out_tag_ff;
   assign rsp_normal_x     = out_n_ff[0];
   assign rsp_normal_y     = out_n_ff[1];
   assign rsp_normal_z     = out_n_ff[2];
   assign rsp_plane_offset = out_off_ff;
   assign rsp_degenerate   = out_deg_ff;

endmodule

FILE: rtl/frustum_plane_from_points.sv
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   plane tag, three Q16.16 points
// rsp       out        rsp_valid/rsp_stall   tag, Q2.30 unit normal, Q16.16 offset, flag
//
// One request per cycle sustained while the response is not stalled; the back pipeline
// holds the 32-step square root and the 31-step normal dividers.
// Reset is synchronous; it empties the front stages, the queue and the back pipeline.
// A stalled response holds the whole back pipeline; the front keeps taking requests
// until the queue and the two front stages together hold four requests.
module frustum_plane_from_points (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_plane_tag,
   input  logic signed [31:0]  req_first_x,
   input  logic signed [31:0]  req_first_y,
   input  logic signed [31:0]  req_first_z,
   input  logic signed [31:0]  req_second_x,
   input  logic signed [31:0]  req_second_y,
   input  logic signed [31:0]  req_second_z,
   input  logic signed [31:0]  req_third_x,
   input  logic signed [31:0]  req_third_y,
   input  logic signed [31:0]  req_third_z,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_tag_out,
   output logic signed [31:0]  rsp_normal_x,
   output logic signed [31:0]  rsp_normal_y,
   output logic signed [31:0]  rsp_normal_z,
   output logic signed [31:0]  rsp_plane_offset,
   output logic                rsp_degenerate
);

   logic                          req_accept;
   logic                          wr_valid;
   fpp_pkg::entry_type            wr_entry;
   fpp_pkg::entry_type            rd_entry;
   logic [fpp_pkg::FCNT_W-1:0]    front_busy;
   logic [fpp_pkg::QCNT_W-1:0]    q_count;
   logic                          q_pop;
   logic [fpp_pkg::QCNT_W:0]      in_flight;

   assign in_flight  = (fpp_pkg::QCNT_W + 1)'(q_count) + (fpp_pkg::QCNT_W + 1)'(front_busy);
   assign req_stall  = in_flight >= (fpp_pkg::QCNT_W + 1)'(fpp_pkg::QUEUE_DEPTH);
   assign req_accept = req_valid && !req_stall;

   fpp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_accept),
      .in_tag    (req_plane_tag),
      .in_first  ({req_first_z, req_first_y, req_first_x}),
      .in_second ({req_second_z, req_second_y, req_second_x}),
      .in_third  ({req_third_z, req_third_y, req_third_x}),
      .wr_valid  (wr_valid),
      .wr_entry  (wr_entry),
      .busy      (front_busy)
   );

   fpp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (wr_valid),
      .push_entry (wr_entry),
      .pop        (q_pop),
      .pop_entry  (rd_entry),
      .count      (q_count)
   );

   fpp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .avail            (q_count != '0),
      .entry            (rd_entry),
      .pop              (q_pop),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_tag_out      (rsp_tag_out),
      .rsp_normal_x     (rsp_normal_x),
      .rsp_normal_y     (rsp_normal_y),
      .rsp_normal_z     (rsp_normal_z),
      .rsp_plane_offset (rsp_plane_offset),
      .rsp_degenerate   (rsp_degenerate)
   );

endmodule

FILE: rtl/fpp_checker.sv
module fpp_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic signed [31:0]  rsp_normal_x,
   input logic signed [31:0]  rsp_normal_y,
   input logic signed [31:0]  rsp_normal_z,
   input logic signed [31:0]  rsp_plane_offset,
   input logic                rsp_degenerate
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_normal_x)
         && $stable(rsp_normal_y) && $stable(rsp_normal_z) && $stable(rsp_plane_offset))
      else $error("stalled response changed");

   a_degenerate_zero: assert property (@(posedge clock)
      rsp_valid && rsp_degenerate |-> rsp_normal_x == 0 && rsp_normal_y == 0
         && rsp_normal_z == 0 && rsp_plane_offset == 0)
      else $error("degenerate response not zero");

   a_unit_range: assert property (@(posedge clock)
      rsp_valid && !rsp_degenerate |->
         rsp_normal_x <= 32'sd1073741824 && rsp_normal_x >= -32'sd1073741824
         && rsp_normal_y <= 32'sd1073741824 && rsp_normal_y >= -32'sd1073741824
         && rsp_normal_z <= 32'sd1073741824 && rsp_normal_z >= -32'sd1073741824
         && (rsp_normal_x != 0 || rsp_normal_y != 0 || rsp_normal_z != 0))
      else $error("normal out of unit range");

endmodule

bind frustum_plane_from_points fpp_checker u_fpp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_normal_x     (rsp_normal_x),
   .rsp_normal_y     (rsp_normal_y),
   .rsp_normal_z     (rsp_normal_z),
   .rsp_plane_offset (rsp_plane_offset),
   .rsp_degenerate   (rsp_degenerate)
);
